// ----- src/ohs_pkg.sv -----
package ohs_pkg;

  localparam int SLOT_COUNT_DEF = 256;
  localparam int KEY_BITS_DEF   = 32;

  localparam int KEY_W   = 32;
  localparam int HASH_W  = 32;
  localparam int POS_W   = 9;
  localparam int CAP_W   = 9;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;
  localparam int TAG_W   = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 3'd0;

  localparam logic [OP_W-1:0] OP_SEARCH = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_ERASE  = 3'd2;
  localparam logic [OP_W-1:0] OP_SCAN   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [TAG_W-1:0] TAG_EMPTY  = 2'd0;
  localparam logic [TAG_W-1:0] TAG_USED   = 2'd1;
  localparam logic [TAG_W-1:0] TAG_ERASED = 2'd2;

  localparam logic [STAT_W-1:0] ST_FOUND = 2'd0;
  localparam logic [STAT_W-1:0] ST_FREE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage

// ----- src/ohs_ram.sv -----
module ohs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/ohs_mod.sv -----
module ohs_mod
  import ohs_pkg::*;
#(
  parameter int NUM_W = HASH_W,
  parameter int DEN_W = CAP_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [DEN_W-1:0] rem
);

  logic                     busy;
  logic [$clog2(NUM_W)-1:0] cnt;
  logic [NUM_W-1:0]         num_sh;
  logic [DEN_W:0]           trial;
  logic [DEN_W:0]           diff;

  // one quotient bit per cycle, restoring form
  assign trial = {rem, num_sh[NUM_W-1]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        num_sh <= num;
        rem    <= '0;
      end else if (busy) begin
        num_sh <= num_sh << 1;
        if (trial >= {1'b0, den}) begin
          rem <= diff[DEN_W-1:0];
        end else begin
          rem <= trial[DEN_W-1:0];
        end
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(NUM_W))'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/open_addressing_hash_set_unit.sv -----
// Channel  | Handshake          | Payload
// ---------+--------------------+-------------------------------------------
// in       | in_valid/in_ready  | opcode, key, key_hash, start_position
// out      | out_valid/out_ready| status, success, position, stored_key
// config   | APB write/read     | capacity_in_use at byte address 0
//
// Search, insert and erase: the hash modulo (bit-serial divider), a read of
// the start slot, a check of each probed slot, a write when the table
// changes, then a load of the output register.
// Scan: a read, a check of each slot examined, then the output load; a start
// at or past the capacity goes straight to the output load.
// Clear, and reset: a sweep over every slot of the tag memory; no
// transaction is accepted during the sweep that follows reset.
// A finished result waits in the output register while the next transaction
// is taken; the loaded next result holds until that register frees.
module open_addressing_hash_set_unit
  import ohs_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    opcode,
  input  logic [KEY_W-1:0]   key,
  input  logic [HASH_W-1:0]  key_hash,
  input  logic [POS_W-1:0]   start_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STAT_W-1:0]  status,
  output logic               success,
  output logic [POS_W-1:0]   position,
  output logic [KEY_W-1:0]   stored_key,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_RD   = 7'b0001000,
    S_CHK  = 7'b0010000,
    S_WR   = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state;

  logic [CAP_W-1:0]    cap_reg;
  logic [CW-1:0]       capa;
  logic [OP_W-1:0]     op;
  logic [KEY_BITS-1:0] key_r;
  logic [IW-1:0]       cur;
  logic [CW-1:0]       cur_inc;
  logic [IW-1:0]       cur_next;
  logic                last;
  logic [CW-1:0]       cnt;
  logic                seen;
  logic [IW-1:0]       first_erased;
  logic [IW-1:0]       clr_idx;
  logic                clr_reply;

  logic [STAT_W-1:0]   res_status;
  logic                res_success;
  logic [CW-1:0]       res_pos;
  logic [KEY_W-1:0]    res_key;

  logic                div_start;
  logic                div_done;
  logic [CW-1:0]       div_rem;

  logic                tag_we;
  logic                key_we;
  logic [IW-1:0]       waddr;
  logic [TAG_W-1:0]    tag_wdata;
  logic [IW-1:0]       raddr;
  logic [TAG_W-1:0]    tag_rd;
  logic [KEY_BITS-1:0] key_rd;

  logic                accept;
  logic                out_free;
  logic                hit;
  logic                seen_now;
  logic [IW-1:0]       fe_now;

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == ADDR_CAPACITY) begin
      prdata = PDATA_W'(cap_reg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= CAP_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_CAPACITY) begin
      cap_reg <= pwdata[CAP_W-1:0];
    end
  end

  // zero acts as one, above the slot count acts as the slot count
  always_comb begin
    if (cap_reg == '0) begin
      capa = CW'(1);
    end else if (32'(cap_reg) > 32'(SLOT_COUNT)) begin
      capa = CW'(SLOT_COUNT);
    end else begin
      capa = CW'(cap_reg);
    end
  end

  assign cur_inc  = CW'(cur) + 1'b1;
  assign last     = (cur_inc == capa);
  assign cur_next = last ? '0 : cur_inc[IW-1:0];

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign div_start = accept && (opcode == OP_SEARCH || opcode == OP_INSERT ||
                                opcode == OP_ERASE);

  ohs_mod #(
    .NUM_W(HASH_W),
    .DEN_W(CW)
  ) u_mod (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (key_hash),
    .den  (capa),
    .done (div_done),
    .rem  (div_rem)
  );

  // read ahead: while checking a slot, fetch the following one
  assign raddr = (state == S_CHK) ? cur_next : cur;

  always_comb begin
    tag_we    = 1'b0;
    key_we    = 1'b0;
    waddr     = res_pos[IW-1:0];
    tag_wdata = TAG_EMPTY;
    unique case (state)
      S_CLR: begin
        tag_we = 1'b1;
        waddr  = clr_idx;
      end
      S_WR: begin
        tag_we    = 1'b1;
        key_we    = (op == OP_INSERT);
        tag_wdata = (op == OP_INSERT) ? TAG_USED : TAG_ERASED;
      end
      default: ;
    endcase
  end

  ohs_ram #(
    .WIDTH(TAG_W),
    .DEPTH(SLOT_COUNT)
  ) u_tags (
    .clk  (clk),
    .we   (tag_we),
    .waddr(waddr),
    .wdata(tag_wdata),
    .raddr(raddr),
    .rdata(tag_rd)
  );

  ohs_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(SLOT_COUNT)
  ) u_keys (
    .clk  (clk),
    .we   (key_we),
    .waddr(waddr),
    .wdata(key_r),
    .raddr(raddr),
    .rdata(key_rd)
  );

  assign hit      = (tag_rd == TAG_USED) && (key_rd == key_r);
  assign seen_now = seen || (tag_rd == TAG_ERASED);
  assign fe_now   = seen ? first_erased : cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      clr_reply <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IW'(SLOT_COUNT - 1)) begin
            clr_reply <= 1'b0;
            state     <= clr_reply ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op          <= opcode;
            key_r       <= KEY_BITS'(key);
            res_status  <= ST_FOUND;
            res_success <= 1'b0;
            res_pos     <= '0;
            res_key     <= '0;
            cnt         <= '0;
            seen        <= 1'b0;
            case (opcode)
              OP_SEARCH, OP_INSERT, OP_ERASE: state <= S_DIV;
              OP_SCAN: begin
                if (32'(start_position) >= 32'(capa)) begin
                  res_pos <= capa;
                  state   <= S_DONE;
                end else begin
                  cur   <= IW'(start_position);
                  state <= S_RD;
                end
              end
              OP_CLEAR: begin
                clr_idx   <= '0;
                clr_reply <= 1'b1;
                state     <= S_CLR;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            cur   <= div_rem[IW-1:0];
            state <= S_RD;
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (op == OP_SCAN) begin
            if (tag_rd == TAG_USED) begin
              res_success <= 1'b1;
              res_pos     <= CW'(cur);
              res_key     <= KEY_W'(key_rd);
              state       <= S_DONE;
            end else if (last) begin
              res_pos <= capa;
              state   <= S_DONE;
            end else begin
              cur <= cur_next;
            end
          end else if (hit) begin
            res_status  <= ST_FOUND;
            res_pos     <= CW'(cur);
            res_success <= (op == OP_ERASE);
            state       <= (op == OP_ERASE) ? S_WR : S_DONE;
          end else if (tag_rd == TAG_EMPTY || seen_now && cnt + 1'b1 == capa) begin
            // stop at an empty slot, or after a full lap that met an erased one
            res_status  <= ST_FREE;
            res_pos     <= CW'(fe_now);
            res_success <= (op == OP_INSERT);
            state       <= (op == OP_INSERT) ? S_WR : S_DONE;
          end else if (cnt + 1'b1 == capa) begin
            res_status <= ST_FULL;
            res_pos    <= CW'(cur);
            state      <= S_DONE;
          end else begin
            seen         <= seen_now;
            first_erased <= fe_now;
            cnt          <= cnt + 1'b1;
            cur          <= cur_next;
          end
        end
        S_WR: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            status     <= res_status;
            success    <= res_success;
            position   <= POS_W'(res_pos);
            stored_key <= res_key;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
